// ===== rtl/lwtc_pkg.sv =====
// package for the level-wind traverse controller
// types, codes and register map shared by all rtl files; no dependencies
`timescale 1ns / 1ps
package lwtc_pkg;

  localparam int TimeBits  = 32;
  localparam int CountBits = 16;
  localparam int CfgBits   = 16;
  localparam logic [1:0] MaxJamRetries = 2'd3;

  typedef logic [TimeBits-1:0]  time_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [CfgBits-1:0]   cfg_val_t;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_RUN    = 3'd1,
    KIND_CENTER = 3'd2,
    KIND_CLRJAM = 3'd3,
    KIND_CLRSTL = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_LIMIT = 2'd2,
    MODE_BACK  = 2'd3
  } mode_e;

  // register indexes
  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_LOCKOUT  = 3'd1;
  localparam logic [2:0] REG_STUCK    = 3'd2;
  localparam logic [2:0] REG_STALL    = 3'd3;
  localparam logic [2:0] REG_DWELL    = 3'd4;
  localparam logic [2:0] REG_CONFIRM  = 3'd5;
  localparam logic [2:0] REG_CENTER   = 3'd6;

  typedef struct packed {
    cfg_val_t debounce_ms;
    cfg_val_t lockout_ms;
    cfg_val_t stuck_ms;
    cfg_val_t stall_trip_ms;
    cfg_val_t break_dwell_ms;
    cfg_val_t break_confirm_ms;
    cfg_val_t centering_back_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0] kind;
    time_t      now_ms;
    logic       switch_pressed;
  } req_t;

  typedef struct packed {
    logic       run_drive;
    logic       dir_drive;
    logic       recovery_speed;
    logic [1:0] motor_mode;
    logic       jam_flag;
    logic       stall_flag;
    logic       limit_event;
    count_t     reversals;
    count_t     rejected_presses;
    count_t     silent_recoveries;
  } rsp_t;

endpackage

// ===== rtl/lwtc_req_if.sv =====
// request channel interface with valid/ready handshake
// depends on lwtc_pkg
`timescale 1ns / 1ps
interface lwtc_req_if import lwtc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  time_t      now_ms;
  logic       switch_pressed;

  modport source (output valid, kind, now_ms, switch_pressed, input ready);
  modport sink (input valid, kind, now_ms, switch_pressed, output ready);
endinterface

// ===== rtl/lwtc_rsp_if.sv =====
// result channel interface with valid/ready handshake
// depends on lwtc_pkg
`timescale 1ns / 1ps
interface lwtc_rsp_if import lwtc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       run_drive;
  logic       dir_drive;
  logic       recovery_speed;
  logic [1:0] motor_mode;
  logic       jam_flag;
  logic       stall_flag;
  logic       limit_event;
  count_t     reversals;
  count_t     rejected_presses;
  count_t     silent_recoveries;

  modport source (output valid, run_drive, dir_drive, recovery_speed, motor_mode, jam_flag,
                  stall_flag, limit_event, reversals, rejected_presses, silent_recoveries,
                  input ready);
  modport sink (input valid, run_drive, dir_drive, recovery_speed, motor_mode, jam_flag,
                stall_flag, limit_event, reversals, rejected_presses, silent_recoveries,
                output ready);
endinterface

// ===== rtl/lwtc_cfg_regs.sv =====
// apb register file holding the seven millisecond timing registers
// depends on lwtc_pkg
`timescale 1ns / 1ps
module lwtc_cfg_regs import lwtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE: cfg_d.debounce_ms       = pwdata[15:0];
        REG_LOCKOUT:  cfg_d.lockout_ms        = pwdata[15:0];
        REG_STUCK:    cfg_d.stuck_ms          = pwdata[15:0];
        REG_STALL:    cfg_d.stall_trip_ms     = pwdata[15:0];
        REG_DWELL:    cfg_d.break_dwell_ms    = pwdata[15:0];
        REG_CONFIRM:  cfg_d.break_confirm_ms  = pwdata[15:0];
        REG_CENTER:   cfg_d.centering_back_ms = pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DEBOUNCE: prdata[15:0] = cfg_q.debounce_ms;
      REG_LOCKOUT:  prdata[15:0] = cfg_q.lockout_ms;
      REG_STUCK:    prdata[15:0] = cfg_q.stuck_ms;
      REG_STALL:    prdata[15:0] = cfg_q.stall_trip_ms;
      REG_DWELL:    prdata[15:0] = cfg_q.break_dwell_ms;
      REG_CONFIRM:  prdata[15:0] = cfg_q.break_confirm_ms;
      REG_CENTER:   prdata[15:0] = cfg_q.centering_back_ms;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms       <= 16'd20;
      cfg_q.lockout_ms        <= 16'd300;
      cfg_q.stuck_ms          <= 16'd3000;
      cfg_q.stall_trip_ms     <= 16'd10000;
      cfg_q.break_dwell_ms    <= 16'd500;
      cfg_q.break_confirm_ms  <= 16'd2000;
      cfg_q.centering_back_ms <= 16'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/level_wind_traverse_controller.sv =====
// Level-wind traverse controller. Each request (tick or operator command) is
// captured in an input register; when the output register is free, a tick runs
// the debouncer, mode step and stall watchdog in one pass (a command applies its
// own state change) and the result lands in an output register. One request per
// cycle is sustained while the consumer drains: a request is taken whenever the
// output register is empty or being drained, so the rate is set only by the consumer.
// depends on lwtc_pkg, lwtc_req_if, lwtc_rsp_if, lwtc_cfg_regs
`timescale 1ns / 1ps
module level_wind_traverse_controller import lwtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lwtc_req_if.sink    req_i,
  lwtc_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;

  lwtc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // pipeline control
  logic in_vld_q, out_vld_q, adv, in_ready;
  req_t in_q;
  rsp_t out_q, out_d;

  assign adv        = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign in_ready   = !in_vld_q || adv;
  assign req_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready) in_vld_q <= req_i.valid;
      if (adv) out_vld_q <= 1'b1;
      else if (rsp_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      in_q.kind           <= req_i.kind;
      in_q.now_ms         <= req_i.now_ms;
      in_q.switch_pressed <= req_i.switch_pressed;
    end
    if (adv) out_q <= out_d;
  end

  // controller state
  logic [1:0] mode_q, mode_d;
  logic running_q, running_d, dir_q, dir_d, run_q, run_d, rec_q, rec_d;
  logic last_q, last_d, stable_q, stable_d, pend_q, pend_d;
  time_t chg_q, chg_d, pstart_q, pstart_d, bstart_q, bstart_d, arm_q, arm_d;
  time_t lrev_q, lrev_d, cstart_q, cstart_d;
  logic [1:0] retr_q, retr_d;
  logic jam_q, jam_d, stl_q, stl_d, bact_q, bact_d, bretr_q, bretr_d;
  count_t snap_q, snap_d, revc_q, revc_d, rejc_q, rejc_d, savc_q, savc_d;
  logic ev;

  // ages are computed from the state entering this request
  time_t now, a_chg, a_lrev, a_pst, a_cst, a_arm, a_brk, a_min;
  logic  sw;
  logic [CfgBits:0] dwell_conf;
  logic  ev_sw, stuck_rev;

  assign now    = in_q.now_ms;
  assign sw     = in_q.switch_pressed;
  assign a_chg  = now - chg_q;
  assign a_pst  = now - pstart_q;
  assign a_cst  = now - cstart_q;
  assign a_arm  = now - arm_q;
  assign a_brk  = now - bstart_q;
  assign dwell_conf = {1'b0, cfg.break_dwell_ms} + {1'b0, cfg.break_confirm_ms};

  always_comb begin
    mode_d = mode_q; running_d = running_q; dir_d = dir_q; run_d = run_q; rec_d = rec_q;
    last_d = last_q; stable_d = stable_q; pend_d = pend_q; chg_d = chg_q;
    pstart_d = pstart_q; bstart_d = bstart_q; arm_d = arm_q; lrev_d = lrev_q;
    cstart_d = cstart_q; retr_d = retr_q; jam_d = jam_q; stl_d = stl_q;
    bact_d = bact_q; bretr_d = bretr_q; snap_d = snap_q; revc_d = revc_q;
    rejc_d = rejc_q; savc_d = savc_q;
    ev = 1'b0; ev_sw = 1'b0; stuck_rev = 1'b0; a_lrev = '0; a_min = '0;

    case (in_q.kind)
      KIND_TICK: begin
        // debounce
        a_lrev = now - lrev_q;
        if (sw != last_q) begin
          last_d = sw;
          chg_d  = now;
        end else if (a_chg >= time_t'(cfg.debounce_ms)) begin
          if (sw == stable_q) begin
            if (stable_q) begin
              if (pend_q && a_lrev >= time_t'(cfg.lockout_ms)) begin
                pend_d = 1'b0;
                ev     = 1'b1;
              end else if (mode_q != MODE_IDLE && a_pst > time_t'(cfg.stuck_ms)) begin
                pstart_d = now;
                if (retr_q < MaxJamRetries) begin
                  retr_d    = retr_q + 2'd1;
                  stuck_rev = 1'b1;
                end else if (!jam_q) begin
                  jam_d = 1'b1; run_d = 1'b0; running_d = 1'b0; mode_d = MODE_IDLE;
                end
              end
            end
          end else begin
            stable_d = sw;
            if (!sw) begin
              retr_d = '0;
              pend_d = 1'b0;
            end else begin
              pstart_d = now;
              if (a_lrev < time_t'(cfg.lockout_ms)) begin
                rejc_d = rejc_q + 1'b1;
                pend_d = 1'b1;
              end else begin
                ev = 1'b1;
              end
            end
          end
        end
        if (stuck_rev) begin
          dir_d = ~dir_d; revc_d = revc_d + 1'b1; lrev_d = now;
        end
        // mode step (uses mode after debounce)
        ev_sw = 1'b0;
        unique case (mode_d)
          MODE_RUN:   ev_sw = ev;
          MODE_LIMIT: if (ev) begin
            ev_sw = 1'b1; mode_d = MODE_BACK; cstart_d = now;
          end
          MODE_BACK: begin
            if (a_cst < time_t'(cfg.centering_back_ms)) ev_sw = ev;
            else begin
              run_d = 1'b0; running_d = 1'b0; mode_d = MODE_IDLE;
            end
          end
          default: ;
        endcase
        if (ev_sw) begin
          dir_d = ~dir_d; revc_d = revc_d + 1'b1; lrev_d = now;
        end
        // stall watchdog
        if (!stl_q) begin
          if (mode_d != MODE_RUN || jam_d) begin
            arm_d = now;
            if (bact_q) begin
              bact_d = 1'b0; bretr_d = 1'b0; rec_d = 1'b0;
            end
          end else if (!bact_q) begin
            a_min = ((now - lrev_d) < a_arm) ? (now - lrev_d) : a_arm;
            if (a_min > time_t'(cfg.stall_trip_ms)) begin
              bact_d = 1'b1; bretr_d = 1'b0; bstart_d = now; snap_d = revc_d;
              run_d = 1'b0;
            end
          end else if (revc_d != snap_q) begin
            bact_d = 1'b0; bretr_d = 1'b0; rec_d = 1'b0;
            savc_d = savc_q + 1'b1;
          end else if (!bretr_q && a_brk >= time_t'(cfg.break_dwell_ms)) begin
            bretr_d = 1'b1; dir_d = ~dir_d; rec_d = 1'b1; run_d = 1'b1;
          end else if (a_brk >= time_t'(dwell_conf)) begin
            bact_d = 1'b0; bretr_d = 1'b0; rec_d = 1'b0; stl_d = 1'b1;
            run_d = 1'b0; running_d = 1'b0; mode_d = MODE_IDLE;
          end
        end
      end
      KIND_RUN: begin
        if (!jam_q && !stl_q && mode_q != MODE_RUN) begin
          mode_d = MODE_RUN; running_d = 1'b1; run_d = 1'b1;
        end
      end
      KIND_CENTER: begin
        if (!jam_q && !stl_q && running_q) begin
          running_d = 1'b0; mode_d = MODE_LIMIT; run_d = 1'b1;
        end
      end
      KIND_CLRJAM: begin
        jam_d = 1'b0; retr_d = '0; pend_d = 1'b0; last_d = sw; stable_d = sw;
        chg_d = now; pstart_d = now;
      end
      KIND_CLRSTL: begin
        stl_d = 1'b0; bact_d = 1'b0; bretr_d = 1'b0; rec_d = 1'b0;
        arm_d = now; lrev_d = now;
      end
      default: ;
    endcase

    out_d.run_drive         = run_d;
    out_d.dir_drive         = dir_d;
    out_d.recovery_speed    = rec_d;
    out_d.motor_mode        = mode_d;
    out_d.jam_flag          = jam_d;
    out_d.stall_flag        = stl_d;
    out_d.limit_event       = ev;
    out_d.reversals         = revc_d;
    out_d.rejected_presses  = rejc_d;
    out_d.silent_recoveries = savc_d;
  end

  // control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE; running_q <= 1'b0; dir_q <= 1'b0; run_q <= 1'b0;
      rec_q <= 1'b0; last_q <= 1'b0; stable_q <= 1'b0; pend_q <= 1'b0;
      chg_q <= '0; pstart_q <= '0; bstart_q <= '0; arm_q <= '0; lrev_q <= '0;
      cstart_q <= '0; retr_q <= '0; jam_q <= 1'b0; stl_q <= 1'b0; bact_q <= 1'b0;
      bretr_q <= 1'b0; snap_q <= '0; revc_q <= '0; rejc_q <= '0; savc_q <= '0;
    end else if (adv) begin
      mode_q <= mode_d; running_q <= running_d; dir_q <= dir_d; run_q <= run_d;
      rec_q <= rec_d; last_q <= last_d; stable_q <= stable_d; pend_q <= pend_d;
      chg_q <= chg_d; pstart_q <= pstart_d; bstart_q <= bstart_d; arm_q <= arm_d;
      lrev_q <= lrev_d; cstart_q <= cstart_d; retr_q <= retr_d; jam_q <= jam_d;
      stl_q <= stl_d; bact_q <= bact_d; bretr_q <= bretr_d; snap_q <= snap_d;
      revc_q <= revc_d; rejc_q <= rejc_d; savc_q <= savc_d;
    end
  end

  // result port
  assign rsp_o.valid             = out_vld_q;
  assign rsp_o.run_drive         = out_q.run_drive;
  assign rsp_o.dir_drive         = out_q.dir_drive;
  assign rsp_o.recovery_speed    = out_q.recovery_speed;
  assign rsp_o.motor_mode        = out_q.motor_mode;
  assign rsp_o.jam_flag          = out_q.jam_flag;
  assign rsp_o.stall_flag        = out_q.stall_flag;
  assign rsp_o.limit_event       = out_q.limit_event;
  assign rsp_o.reversals         = out_q.reversals;
  assign rsp_o.rejected_presses  = out_q.rejected_presses;
  assign rsp_o.silent_recoveries = out_q.silent_recoveries;

endmodule
